FILE: sv/ptmr_pkg.sv
// Shared types, constants and functions for the Miller-Rabin prime test unit.
package ptmr_pkg;

    localparam int unsigned WordWidth = 64;
    localparam int unsigned NumBases  = 12;
    localparam int unsigned BaseIdxW  = 4;
    localparam int unsigned BitCntW   = 7;

    typedef logic [WordWidth-1:0] word_t;
    typedef logic [BaseIdxW-1:0]  base_idx_t;
    typedef logic [BitCntW-1:0]   bit_cnt_t;

    // Control sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SIEVE,
        ST_SIEVE_WAIT,
        ST_SPLIT,
        ST_BASE_INIT,
        ST_POW_STEP,
        ST_POW_WAIT,
        ST_SQR_CHECK,
        ST_SQR_WAIT,
        ST_DONE
    } state_t;

    // Modular multiplier states
    typedef enum logic [1:0] {
        MM_IDLE,
        MM_DBL,
        MM_ADD
    } mm_state_t;

    typedef struct packed {
        logic start;
    } mm_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mm_status_t;

    function automatic word_t base_value(input base_idx_t idx);
        word_t v;
        unique case (idx)
            4'd0:    v = word_t'(2);
            4'd1:    v = word_t'(3);
            4'd2:    v = word_t'(5);
            4'd3:    v = word_t'(7);
            4'd4:    v = word_t'(11);
            4'd5:    v = word_t'(13);
            4'd6:    v = word_t'(17);
            4'd7:    v = word_t'(19);
            4'd8:    v = word_t'(23);
            4'd9:    v = word_t'(29);
            4'd10:   v = word_t'(31);
            4'd11:   v = word_t'(37);
            default: v = word_t'(2);
        endcase
        return v;
    endfunction

    // (a + b) mod m for a, b < m
    function automatic word_t add_mod(input word_t a, input word_t b, input word_t m);
        word_t room;
        room = m - b;
        return (a >= room) ? (a - room) : (a + b);
    endfunction

endpackage

FILE: sv/ptmr_modmul.sv
// Bit-serial modular multiplier: one doubling and one conditional add per multiplier bit.
module ptmr_modmul (
    input  logic               clk,
    input  logic               rst_n,
    input  ptmr_pkg::mm_req_t  req,
    input  ptmr_pkg::word_t    a,
    input  ptmr_pkg::word_t    b,
    input  ptmr_pkg::word_t    m,
    output ptmr_pkg::mm_status_t status,
    output ptmr_pkg::word_t    product
);
    import ptmr_pkg::*;

    mm_state_t state_reg, state_next;
    bit_cnt_t  cnt_reg, cnt_next;
    word_t     acc_reg, acc_next;
    word_t     a_reg, a_next;
    word_t     b_reg, b_next;
    logic      done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MM_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            MM_IDLE:
            begin
                if (req.start)
                begin
                    acc_next   = '0;
                    a_next     = a;
                    b_next     = b;
                    cnt_next   = bit_cnt_t'(WordWidth);
                    state_next = MM_DBL;
                end
            end
            MM_DBL:
            begin
                acc_next   = add_mod(acc_reg, acc_reg, m);
                state_next = MM_ADD;
            end
            MM_ADD:
            begin
                // take the top multiplier bit, then shift it out
                if (b_reg[WordWidth-1])
                    acc_next = add_mod(acc_reg, a_reg, m);
                b_next   = {b_reg[WordWidth-2:0], 1'b0};
                cnt_next = cnt_reg - bit_cnt_t'(1);
                if (cnt_reg == bit_cnt_t'(1))
                begin
                    state_next = MM_IDLE;
                    done_next  = 1'b1;
                end
                else
                    state_next = MM_DBL;
            end
            default: state_next = MM_IDLE;
        endcase
    end

    assign status.busy = (state_reg != MM_IDLE);
    assign status.done = done_reg;
    assign product     = acc_reg;

endmodule

FILE: sv/ptmr_sieve.sv
// Serial remainder of the candidate by a small prime, one bit per cycle.
module ptmr_sieve (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  ptmr_pkg::word_t n,
    input  ptmr_pkg::word_t divisor,
    output logic            done,
    output logic            is_zero
);
    import ptmr_pkg::*;

    logic     busy_reg, busy_next;
    logic     done_reg, done_next;
    bit_cnt_t cnt_reg, cnt_next;
    word_t    sh_reg, sh_next;
    logic [6:0] rem_reg, rem_next;
    logic [7:0] trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, sh_reg[WordWidth-1]};
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            sh_next   = n;
            rem_next  = '0;
            cnt_next  = bit_cnt_t'(WordWidth);
        end
        else if (busy_reg)
        begin
            // restoring step: remainder stays below 37
            if (trial >= divisor[7:0])
                rem_next = 7'(trial - divisor[7:0]);
            else
                rem_next = trial[6:0];
            sh_next  = {sh_reg[WordWidth-2:0], 1'b0};
            cnt_next = cnt_reg - bit_cnt_t'(1);
            if (cnt_reg == bit_cnt_t'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done    = done_reg;
    assign is_zero = (rem_reg == '0);

endmodule

FILE: sv/prime_test_miller_rabin_64_unit.sv
// Top level of the deterministic 64-bit Miller-Rabin prime test.
//   channel | signals                         | direction
//   in      | in_valid, in_ready, candidate   | word into unit
//   out     | out_valid, out_ready, is_prime  | word out of unit
// One candidate at a time; the next is taken once the result register is free.
// Sieve: one serial remainder per small prime (up to 12 primes); a base needs
// up to 126 modular products. The worst-case run time is set by the multiplier.
// Reset clears control state; out_ready low holds the result and blocks new input.
module prime_test_miller_rabin_64_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ptmr_pkg::word_t candidate,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            is_prime
);
    import ptmr_pkg::*;

    state_t     state_reg, state_next;
    word_t      n_reg, n_next;
    word_t      d_reg, d_next;
    word_t      e_reg, e_next;
    word_t      acc_reg, acc_next;
    word_t      x_reg, x_next;
    bit_cnt_t   s_reg, s_next;
    bit_cnt_t   k_reg, k_next;
    base_idx_t  idx_reg, idx_next;
    logic       phase_reg, phase_next;
    logic       out_valid_reg, out_valid_next;
    logic       result_reg, result_next;

    mm_req_t    mm_req;
    mm_status_t mm_status;
    word_t      mm_a, mm_b, mm_p;
    logic       sv_start, sv_done, sv_zero;
    word_t      n_m1;

    ptmr_sieve u_sieve (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sv_start),
        .n       (n_reg),
        .divisor (base_value(idx_reg)),
        .done    (sv_done),
        .is_zero (sv_zero)
    );

    ptmr_modmul u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mm_req),
        .a       (mm_a),
        .b       (mm_b),
        .m       (n_reg),
        .status  (mm_status),
        .product (mm_p)
    );

    assign n_m1 = n_reg - word_t'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        d_reg      <= d_next;
        e_reg      <= e_next;
        acc_reg    <= acc_next;
        x_reg      <= x_next;
        s_reg      <= s_next;
        k_reg      <= k_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        e_next         = e_reg;
        acc_next       = acc_reg;
        x_next         = x_reg;
        s_next         = s_reg;
        k_next         = k_reg;
        idx_next       = idx_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        sv_start       = 1'b0;
        mm_req.start   = 1'b0;
        mm_a           = acc_reg;
        mm_b           = x_reg;
        in_ready       = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = !out_valid_reg;
                if (in_valid && !out_valid_reg)
                begin
                    n_next   = candidate;
                    idx_next = '0;
                    if (candidate < word_t'(2))
                    begin
                        result_next = 1'b0;
                        state_next  = ST_DONE;
                    end
                    else
                        state_next = ST_SIEVE;
                end
            end
            ST_SIEVE:
            begin
                sv_start   = 1'b1;
                state_next = ST_SIEVE_WAIT;
            end
            ST_SIEVE_WAIT:
            begin
                if (sv_done)
                begin
                    priority if (sv_zero)
                    begin
                        result_next = (n_reg == base_value(idx_reg));
                        state_next  = ST_DONE;
                    end
                    else if (idx_reg == base_idx_t'(NumBases - 1))
                    begin
                        d_next     = n_m1;
                        s_next     = '0;
                        state_next = ST_SPLIT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + base_idx_t'(1);
                        state_next = ST_SIEVE;
                    end
                end
            end
            ST_SPLIT:
            begin
                // strip one trailing zero per cycle
                if (d_reg[0])
                begin
                    idx_next   = '0;
                    state_next = ST_BASE_INIT;
                end
                else
                begin
                    d_next = {1'b0, d_reg[WordWidth-1:1]};
                    s_next = s_reg + bit_cnt_t'(1);
                end
            end
            ST_BASE_INIT:
            begin
                acc_next   = word_t'(1);
                x_next     = base_value(idx_reg);
                e_next     = d_reg;
                phase_next = 1'b0;
                state_next = ST_POW_STEP;
            end
            ST_POW_STEP:
            begin
                priority if (e_reg == '0)
                begin
                    x_next     = acc_reg;
                    k_next     = bit_cnt_t'(1);
                    state_next = ST_SQR_CHECK;
                end
                else if (!phase_reg && !e_reg[0])
                    phase_next = 1'b1;
                else
                begin
                    mm_a         = phase_reg ? x_reg : acc_reg;
                    mm_b         = x_reg;
                    mm_req.start = 1'b1;
                    state_next   = ST_POW_WAIT;
                end
            end
            ST_POW_WAIT:
            begin
                mm_a = phase_reg ? x_reg : acc_reg;
                if (mm_status.done)
                begin
                    if (phase_reg)
                    begin
                        x_next     = mm_p;
                        e_next     = {1'b0, e_reg[WordWidth-1:1]};
                        phase_next = 1'b0;
                    end
                    else
                    begin
                        acc_next   = mm_p;
                        phase_next = 1'b1;
                    end
                    state_next = ST_POW_STEP;
                end
            end
            ST_SQR_CHECK:
            begin
                // one is a pass only straight after the power, n-1 at any point
                priority if ((x_reg == word_t'(1) && k_reg == bit_cnt_t'(1)) || x_reg == n_m1)
                begin
                    if (idx_reg == base_idx_t'(NumBases - 1))
                    begin
                        result_next = 1'b1;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + base_idx_t'(1);
                        state_next = ST_BASE_INIT;
                    end
                end
                else if (k_reg >= s_reg || (k_reg > bit_cnt_t'(1) && x_reg == word_t'(1)))
                begin
                    result_next = 1'b0;
                    state_next  = ST_DONE;
                end
                else
                begin
                    mm_a         = x_reg;
                    mm_b         = x_reg;
                    mm_req.start = 1'b1;
                    state_next   = ST_SQR_WAIT;
                end
            end
            ST_SQR_WAIT:
            begin
                mm_a = x_reg;
                if (mm_status.done)
                begin
                    x_next = mm_p;
                    k_next = k_reg + bit_cnt_t'(1);
                    // only n-1 rescues after squaring
                    if (mm_p == n_m1)
                        state_next = ST_SQR_CHECK;
                    else if (k_reg + bit_cnt_t'(1) >= s_reg)
                    begin
                        result_next = 1'b0;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        mm_a         = mm_p;
                        state_next   = ST_SQR_CHECK;
                        x_next       = mm_p;
                    end
                end
            end
            ST_DONE:
            begin
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign is_prime  = result_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == ST_IDLE))
        else $error("in_ready outside idle");

    a_done_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> out_valid)
        else $error("result not presented");

    a_mm_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mm_req.start |-> !mm_status.busy)
        else $error("multiplier started while busy");

endmodule
